FILE: hdl/ksd_pkg.sv
package ksd_pkg;

  // bound of the character table codes; codes at or above it read as no character
  localparam int unsigned TABLE_ENTRIES = 96;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ENABLED         = 2'd0;
  localparam reg_idx_t REG_REPEAT_DELAY    = 2'd1;
  localparam reg_idx_t REG_REPEAT_INTERVAL = 2'd2;

  // reset values of the repeat timing registers
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd500;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd70;

  // modifier key codes occupy 0x60..0x67
  localparam logic [3:0] MOD_CODE_HI = 4'b1100;

  // input item kinds
  localparam logic FUNC_SCANCODE = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  // modifier register bits
  localparam int unsigned MOD_CTRL = 3;

  typedef struct packed {
    logic [7:0] key_code;
    logic [6:0] character;
  } key_event_t;

  // character table, returns {shifted, unshifted}
  function automatic logic [13:0] char_rom(input logic [6:0] code);
    logic [13:0] r;
    unique case (code)
      7'd0:  r = {7'h7e, 7'h60};
      7'd1:  r = {7'h21, 7'h31};
      7'd2:  r = {7'h40, 7'h32};
      7'd3:  r = {7'h23, 7'h33};
      7'd4:  r = {7'h24, 7'h34};
      7'd5:  r = {7'h25, 7'h35};
      7'd6:  r = {7'h5e, 7'h36};
      7'd7:  r = {7'h26, 7'h37};
      7'd8:  r = {7'h2a, 7'h38};
      7'd9:  r = {7'h28, 7'h39};
      7'd10: r = {7'h29, 7'h30};
      7'd11: r = {7'h5f, 7'h2d};
      7'd12: r = {7'h2b, 7'h3d};
      7'd13: r = {7'h7c, 7'h5c};
      7'd15: r = {7'h30, 7'h30};
      7'd16: r = {7'h51, 7'h71};
      7'd17: r = {7'h57, 7'h77};
      7'd18: r = {7'h45, 7'h65};
      7'd19: r = {7'h52, 7'h72};
      7'd20: r = {7'h54, 7'h74};
      7'd21: r = {7'h59, 7'h79};
      7'd22: r = {7'h55, 7'h75};
      7'd23: r = {7'h49, 7'h69};
      7'd24: r = {7'h4f, 7'h6f};
      7'd25: r = {7'h50, 7'h70};
      7'd26: r = {7'h7b, 7'h5b};
      7'd27: r = {7'h7d, 7'h5d};
      7'd29: r = {7'h31, 7'h31};
      7'd30: r = {7'h32, 7'h32};
      7'd31: r = {7'h33, 7'h33};
      7'd32: r = {7'h41, 7'h61};
      7'd33: r = {7'h53, 7'h73};
      7'd34: r = {7'h44, 7'h64};
      7'd35: r = {7'h46, 7'h66};
      7'd36: r = {7'h47, 7'h67};
      7'd37: r = {7'h48, 7'h68};
      7'd38: r = {7'h4a, 7'h6a};
      7'd39: r = {7'h4b, 7'h6b};
      7'd40: r = {7'h4c, 7'h6c};
      7'd41: r = {7'h3a, 7'h3b};
      7'd42: r = {7'h22, 7'h27};
      7'd45: r = {7'h34, 7'h34};
      7'd46: r = {7'h35, 7'h35};
      7'd47: r = {7'h36, 7'h36};
      7'd49: r = {7'h5a, 7'h7a};
      7'd50: r = {7'h58, 7'h78};
      7'd51: r = {7'h43, 7'h63};
      7'd52: r = {7'h56, 7'h76};
      7'd53: r = {7'h42, 7'h62};
      7'd54: r = {7'h4e, 7'h6e};
      7'd55: r = {7'h4d, 7'h6d};
      7'd56: r = {7'h3c, 7'h2c};
      7'd57: r = {7'h3e, 7'h2e};
      7'd58: r = {7'h3f, 7'h2f};
      7'd60: r = {7'h2e, 7'h2e};
      7'd61: r = {7'h37, 7'h37};
      7'd62: r = {7'h38, 7'h38};
      7'd63: r = {7'h39, 7'h39};
      7'd64: r = {7'h20, 7'h20};
      7'd65: r = {7'h08, 7'h08};
      7'd66: r = {7'h0f, 7'h09};
      7'd67: r = {7'h0d, 7'h0d};
      7'd68: r = {7'h0d, 7'h0d};
      7'd69: r = {7'h1b, 7'h1b};
      7'd70: r = {7'h7f, 7'h7f};
      7'd74: r = {7'h2d, 7'h2d};
      7'd76: r = {7'h00, 7'h10};
      7'd77: r = {7'h00, 7'h0e};
      7'd78: r = {7'h05, 7'h06};
      7'd79: r = {7'h01, 7'h02};
      7'd90: r = {7'h28, 7'h28};
      7'd91: r = {7'h29, 7'h29};
      7'd92: r = {7'h2f, 7'h2f};
      7'd93: r = {7'h2a, 7'h2a};
      7'd94: r = {7'h2b, 7'h2b};
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // press code to character under the current modifiers
  function automatic logic [6:0] translate(input logic [6:0] code, input logic [7:0] mods);
    logic [13:0] row;
    logic [6:0]  ch;
    row = char_rom(code);
    ch  = row[6:0];
    if ({1'b0, code} >= 8'(TABLE_ENTRIES)) begin
      ch = 7'd0;
    end else if (mods[2:0] != 3'd0) begin
      ch = row[13:7];
    end else if (mods[MOD_CTRL]) begin
      priority if (ch >= 7'h61 && ch <= 7'h7a) begin
        ch = ch - 7'h60;
      end else if (ch == 7'd2) begin
        ch = 7'd1;
      end else if (ch == 7'd6) begin
        ch = 7'd5;
      end
    end
    return ch;
  endfunction

endpackage

FILE: hdl/keyboard_scancode_decoder.sv
// channel  direction  handshake                payload
// in       input      in_valid / in_stall      in_func, in_raw_byte
// out      output     out_valid / out_stall    out_key_code, out_character
// cfg      input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// one item per cycle unless stalled: a beat enters the input register, is decoded against
// the key state and the character table, and its result is registered in out_r.
// the decode stage advances unless it makes a result while the result register is full
// and stalled; items that make no result never wait on the output side.
// rst_n is synchronous and active low; it clears control state and loads register defaults.
module keyboard_scancode_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [7:0]                      in_raw_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_key_code,
  output logic [6:0]                      out_character,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ksd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ksd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ksd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ksd_pkg::*;

  // configuration registers
  logic        enabled_r;
  logic [15:0] repeat_delay_r;
  logic [15:0] repeat_interval_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // input register
  logic        in_vld_r;
  logic        in_func_r;
  logic [7:0]  in_raw_r;

  // key state
  logic [7:0]  mods_r, mods_nxt;
  logic [7:0]  last_raw_r, last_raw_nxt;
  key_event_t  held_r, held_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] countdown_r, countdown_nxt;

  // result register
  logic        out_valid_r;
  key_event_t  out_r;

  // decode
  logic        emit;
  key_event_t  ev;
  logic        adv;
  logic        in_take;
  logic [7:0]  code;
  logic        is_mod;
  logic [7:0]  mod_bit;
  logic [6:0]  ch;

  // apb access
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_ENABLED:         prdata = {{(CFG_DATA_W-1){1'b0}}, enabled_r};
      REG_REPEAT_DELAY:    prdata = {{(CFG_DATA_W-16){1'b0}}, repeat_delay_r};
      REG_REPEAT_INTERVAL: prdata = {{(CFG_DATA_W-16){1'b0}}, repeat_interval_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r         <= 1'b0;
      repeat_delay_r    <= REPEAT_DELAY_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLED:         enabled_r         <= pwdata[0];
        REG_REPEAT_DELAY:    repeat_delay_r    <= pwdata[15:0];
        REG_REPEAT_INTERVAL: repeat_interval_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // scancode decode: rotate right by one and invert
  assign code    = ~{in_raw_r[0], in_raw_r[7:1]};
  assign is_mod  = (code[6:3] == MOD_CODE_HI);
  assign mod_bit = is_mod ? (8'd1 << code[2:0]) : 8'd0;
  assign ch      = translate(code[6:0], mods_r);

  // next key state and result for the item in the input register
  always_comb begin
    mods_nxt      = mods_r;
    last_raw_nxt  = last_raw_r;
    held_nxt      = held_r;
    armed_nxt     = armed_r;
    countdown_nxt = countdown_r;
    emit          = 1'b0;
    ev            = held_r;
    if (in_func_r == FUNC_TICK) begin
      // autorepeat timing
      if (held_r.character != 7'd0) begin
        if (!armed_r) begin
          armed_nxt     = 1'b1;
          countdown_nxt = repeat_delay_r;
        end else if (countdown_r[15:1] == 15'd0) begin
          countdown_nxt = repeat_interval_r;
          emit          = 1'b1;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
    end else if (enabled_r) begin
      armed_nxt = 1'b0;
      if (in_raw_r != last_raw_r) begin
        last_raw_nxt = in_raw_r;
        mods_nxt     = code[7] ? (mods_r & ~mod_bit) : (mods_r | mod_bit);
        if (!is_mod && !code[7]) begin
          // ordinary press
          ev       = '{key_code: code, character: ch};
          held_nxt = (ch == 7'd0) ? '0 : ev;
          emit     = (ch != 7'd0);
        end else begin
          // release or modifier
          held_nxt = '0;
          ev       = '{key_code: code, character: 7'd0};
          emit     = 1'b1;
        end
      end
    end
  end

  // stage control
  assign adv      = !emit || !out_valid_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take || (in_vld_r && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r <= in_func;
      in_raw_r  <= in_raw_byte;
    end
  end

  // state update when the decode stage moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r      <= '0;
      last_raw_r  <= '0;
      held_r      <= '0;
      armed_r     <= 1'b0;
      countdown_r <= '0;
    end else if (in_vld_r && adv) begin
      mods_r      <= mods_nxt;
      last_raw_r  <= last_raw_nxt;
      held_r      <= held_nxt;
      armed_r     <= armed_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_vld_r && emit && adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r && emit && adv) begin
      out_r <= ev;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_code  = out_r.key_code;
  assign out_character = out_r.character;

  // checks
  a_armed_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (held_r.character != 7'd0))
    else $error("autorepeat armed with nothing held");

  a_release_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.key_code[7]) |-> (out_r.character == 7'd0))
    else $error("release beat carries a character");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_vld_r))
    else $error("result appeared without a decoded item");

  a_full_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule
